// File: design/tfl_pkg.sv
`timescale 1ns / 1ps

package tfl_pkg;

  // Geometry of the buffer.
  localparam int unsigned CAPACITY = 16;
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);

  // Field widths.
  localparam int unsigned PID_W   = 16;
  localparam int unsigned PAGE_W  = 20;
  localparam int unsigned FRAME_W = 20;
  localparam int unsigned STAMP_W = 32;
  localparam int unsigned CFG_W   = 5;

  // Configuration register indexes.
  localparam logic REG_ENTRIES_IN_USE = 1'b0;
  localparam logic REG_REPLACE_POLICY = 1'b1;

  // Replacement policy codes.
  localparam logic POLICY_FIFO = 1'b0;
  localparam logic POLICY_LRU  = 1'b1;

  typedef enum logic [1:0] {
    CMD_LOOKUP       = 2'd0,
    CMD_FILL         = 2'd1,
    CMD_FLUSH_PID    = 2'd2,
    CMD_FLUSH_RESIZE = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ACT_IGNORED  = 2'd0,
    ACT_APPENDED = 2'd1,
    ACT_REPLACED = 2'd2
  } fill_act_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_SHIFT
  } state_e;

  // One translation entry.
  typedef struct packed {
    logic [PID_W-1:0]   pid;
    logic [PAGE_W-1:0]  page;
    logic [FRAME_W-1:0] frame;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  // Running least-stamp candidate handed down the chain.
  typedef struct packed {
    logic               valid;
    logic [STAMP_W-1:0] stamp;
    logic [IDX_W-1:0]   idx;
  } token_t;

  // Controls shared by every cell.
  typedef struct packed {
    logic              mark_load;
    logic              shift;
    logic              use_thr;
    logic [PAGE_W-1:0] thr;
    logic [PID_W-1:0]  key_pid;
    logic [PAGE_W-1:0] key_page;
    entry_t            wdata;
  } ctrl_t;

  // Controls addressed to one cell.
  typedef struct packed {
    logic in_list;
    logic wr_entry;
    logic wr_stamp;
  } cell_sel_t;

endpackage

// File: design/tfl_cell.sv
`timescale 1ns / 1ps

module tfl_cell
  import tfl_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [IDX_W-1:0]    idx_i,
  input  ctrl_t               ctrl_i,
  input  cell_sel_t           sel_i,
  input  entry_t              nxt_entry_i,
  input  logic                nxt_mark_i,
  input  logic                seen_i,
  output logic                seen_o,
  input  token_t              tok_i,
  output token_t              tok_o,
  output entry_t              entry_o,
  output logic                mark_o,
  output logic                match_o
);

  entry_t entry_q, entry_d;
  logic   mark_q, mark_d;
  token_t tok_q, tok_d;
  logic   drop;
  logic   take_own;

  // A cell is removed when its process matches and, on a resize flush,
  // its page lies at or above the threshold.
  assign drop = sel_i.in_list && (entry_q.pid == ctrl_i.key_pid) &&
                (!ctrl_i.use_thr || (entry_q.page >= ctrl_i.thr));

  // The marked region starts at the first marked cell; every cell from there
  // on pulls its neighbor's contents during a shift.
  assign seen_o = seen_i | mark_q;

  assign match_o = sel_i.in_list && (entry_q.pid == ctrl_i.key_pid) &&
                   (entry_q.page == ctrl_i.key_page);

  // Entry and mark storage: shift down, mark load, full write or restamp.
  always_comb begin
    entry_d = entry_q;
    mark_d  = mark_q;
    if (ctrl_i.shift && seen_o) begin
      entry_d = nxt_entry_i;
      mark_d  = nxt_mark_i;
    end else if (ctrl_i.mark_load) begin
      mark_d = drop;
    end else if (sel_i.wr_entry) begin
      entry_d = ctrl_i.wdata;
    end else if (sel_i.wr_stamp) begin
      entry_d.stamp = ctrl_i.wdata.stamp;
    end
  end

  // Least-stamp candidate: keep the upstream one on ties so that the first
  // entry in list order wins.
  assign take_own = !tok_i.valid || (entry_q.stamp < tok_i.stamp);

  always_comb begin
    if (take_own) begin
      tok_d.valid = 1'b1;
      tok_d.stamp = entry_q.stamp;
      tok_d.idx   = idx_i;
    end else begin
      tok_d = tok_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
    tok_q   <= tok_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mark_q <= 1'b0;
    end else begin
      mark_q <= mark_d;
    end
  end

  assign tok_o   = tok_q;
  assign entry_o = entry_q;
  assign mark_o  = mark_q;

endmodule

// File: design/tlb_fifo_lru_replacement.sv
`timescale 1ns / 1ps

// Translation lookaside buffer of CAPACITY entries held in a row of cells,
// kept as a compacted list in fill order. One item is in work at a time; the
// input side stalls until its result is in the output register, and a waiting
// result does not block the next item from being taken. A lookup, an append
// and a FIFO replacement finish in the execute state. An LRU replacement
// first lets the least-stamp candidate walk down the chain one cell per cycle.
// A flush marks the entries to remove, then the list closes up by one
// position per cycle. Configuration writes are taken at any time and must
// only be issued while the block idles.
module tlb_fifo_lru_replacement
  import tfl_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // Configuration write port.
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [CFG_W-1:0]    cfg_data_i,
  // Input channel.
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          cmd_i,
  input  logic [PID_W-1:0]    process_id_i,
  input  logic [PAGE_W-1:0]   page_i,
  input  logic [FRAME_W-1:0]  frame_in_i,
  input  logic [PAGE_W-1:0]   new_page_count_i,
  // Output channel.
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                hit_o,
  output logic [FRAME_W-1:0]  frame_out_o,
  output logic [1:0]          fill_action_o,
  output logic [CNT_W-1:0]    removed_count_o
);

  state_e state_q, state_d;

  logic [CFG_W-1:0]   eiu_q;
  logic               policy_q;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [IDX_W-1:0]   fifo_q, fifo_d;
  logic [STAMP_W-1:0] stamp_q, stamp_d;
  logic [IDX_W-1:0]   scan_q, scan_d;
  logic [CNT_W-1:0]   removed_q, removed_d;

  cmd_e               cmd_q;
  logic [PID_W-1:0]   pid_q;
  logic [PAGE_W-1:0]  page_q;
  logic [FRAME_W-1:0] frame_q;
  logic [PAGE_W-1:0]  npc_q;

  logic               out_valid_q, out_valid_d;
  logic               hit_q, hit_d;
  logic [FRAME_W-1:0] frame_out_q, frame_out_d;
  fill_act_e          act_q, act_d;
  logic [CNT_W-1:0]   rm_out_q, rm_out_d;

  ctrl_t              ctrl;
  cell_sel_t          sel [CAPACITY];
  entry_t             cell_entry [CAPACITY];
  logic [CAPACITY-1:0] cell_mark;
  logic [CAPACITY-1:0] cell_match;
  logic [CAPACITY:0]  seen;
  token_t             tok [CAPACITY+1];

  logic               accept;
  logic               out_free;
  logic               finish;
  logic [CNT_W-1:0]   limit;
  logic               hit_any;
  logic [IDX_W-1:0]   hit_idx;
  logic [IDX_W-1:0]   last_idx;
  logic [IDX_W-1:0]   victim;
  logic [CNT_W-1:0]   victim_nxt;
  logic               fill_scan;
  logic               any_mark;

  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign in_stall_o = (state_q != ST_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;

  // Fill limit clipped to the capacity.
  assign limit    = (eiu_q > CNT_W'(CAPACITY)) ? CNT_W'(CAPACITY) : eiu_q;
  assign last_idx = IDX_W'(count_q - CNT_W'(1));
  assign any_mark = seen[CAPACITY];

  // A fill into a full list under LRU needs the chain scan.
  assign fill_scan = (limit != '0) && (count_q >= limit) && (policy_q == POLICY_LRU);

  // FIFO victim, falling back to entry 0 when the pointer is past the list.
  assign victim     = (CNT_W'(fifo_q) < count_q) ? fifo_q : '0;
  assign victim_nxt = CNT_W'(victim) + CNT_W'(1);

  // First matching entry in list order.
  always_comb begin
    hit_any = 1'b0;
    hit_idx = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (cell_match[i]) begin
        hit_any = 1'b1;
        hit_idx = IDX_W'(i);
      end
    end
  end

  // Cell chain.
  assign seen[0] = 1'b0;
  assign tok[0]  = '0;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    entry_t nxt_entry;
    logic   nxt_mark;
    if (g == CAPACITY - 1) begin : g_tail
      assign nxt_entry = '0;
      assign nxt_mark  = 1'b0;
    end else begin : g_body
      assign nxt_entry = cell_entry[g+1];
      assign nxt_mark  = cell_mark[g+1];
    end

    tfl_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .idx_i       (IDX_W'(g)),
      .ctrl_i      (ctrl),
      .sel_i       (sel[g]),
      .nxt_entry_i (nxt_entry),
      .nxt_mark_i  (nxt_mark),
      .seen_i      (seen[g]),
      .seen_o      (seen[g+1]),
      .tok_i       (tok[g]),
      .tok_o       (tok[g+1]),
      .entry_o     (cell_entry[g]),
      .mark_o      (cell_mark[g]),
      .match_o     (cell_match[g])
    );
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if ((cmd_q == CMD_FLUSH_PID) || (cmd_q == CMD_FLUSH_RESIZE)) begin
          state_d = ST_SHIFT;
        end else if ((cmd_q == CMD_FILL) && fill_scan) begin
          state_d = ST_SCAN;
        end else if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if ((scan_q == last_idx) && out_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_SHIFT: begin
        if (!any_mark && out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Cell controls, bookkeeping and result.
  always_comb begin
    ctrl.mark_load   = 1'b0;
    ctrl.shift       = 1'b0;
    ctrl.use_thr     = (cmd_q == CMD_FLUSH_RESIZE) && (npc_q != '0);
    ctrl.thr         = npc_q - PAGE_W'(1);
    ctrl.key_pid     = pid_q;
    ctrl.key_page    = page_q;
    ctrl.wdata.pid   = pid_q;
    ctrl.wdata.page  = page_q;
    ctrl.wdata.frame = frame_q;
    ctrl.wdata.stamp = stamp_q;
    for (int i = 0; i < CAPACITY; i++) begin
      sel[i].in_list  = (CNT_W'(i) < count_q);
      sel[i].wr_entry = 1'b0;
      sel[i].wr_stamp = 1'b0;
    end

    count_d     = count_q;
    fifo_d      = fifo_q;
    stamp_d     = stamp_q;
    scan_d      = scan_q;
    removed_d   = removed_q;
    finish      = 1'b0;
    hit_d       = 1'b0;
    frame_out_d = '0;
    act_d       = ACT_IGNORED;
    rm_out_d    = '0;

    unique case (state_q)
      ST_EXEC: begin
        unique case (cmd_q) inside
          CMD_LOOKUP: begin
            if (out_free) begin
              finish = 1'b1;
              if (hit_any) begin
                hit_d       = 1'b1;
                frame_out_d = cell_entry[hit_idx].frame;
                if (policy_q == POLICY_LRU) begin
                  sel[hit_idx].wr_stamp = 1'b1;
                  stamp_d               = stamp_q + STAMP_W'(1);
                end
              end
            end
          end
          CMD_FILL: begin
            if (fill_scan) begin
              scan_d = '0;
            end else if (out_free) begin
              finish = 1'b1;
              if (limit == '0) begin
                act_d = ACT_IGNORED;
              end else if (count_q < limit) begin
                sel[IDX_W'(count_q)].wr_entry = 1'b1;
                count_d = count_q + CNT_W'(1);
                stamp_d = stamp_q + STAMP_W'(1);
                act_d   = ACT_APPENDED;
              end else begin
                sel[victim].wr_entry = 1'b1;
                fifo_d  = (victim_nxt >= count_q) ? '0 : IDX_W'(victim_nxt);
                stamp_d = stamp_q + STAMP_W'(1);
                act_d   = ACT_REPLACED;
              end
            end
          end
          CMD_FLUSH_PID, CMD_FLUSH_RESIZE: begin
            ctrl.mark_load = 1'b1;
            removed_d      = '0;
          end
          default: ;
        endcase
      end
      ST_SCAN: begin
        if (scan_q == last_idx) begin
          if (out_free) begin
            finish = 1'b1;
            // The candidate leaving the last listed cell covers the whole list.
            sel[tok[count_q].idx].wr_entry = 1'b1;
            stamp_d = stamp_q + STAMP_W'(1);
            act_d   = ACT_REPLACED;
          end
        end else begin
          scan_d = scan_q + IDX_W'(1);
        end
      end
      ST_SHIFT: begin
        if (any_mark) begin
          ctrl.shift = 1'b1;
          count_d    = count_q - CNT_W'(1);
          removed_d  = removed_q + CNT_W'(1);
        end else if (out_free) begin
          finish   = 1'b1;
          rm_out_d = removed_q;
        end
      end
      default: ;
    endcase
  end

  // Output register.
  assign out_valid_d = finish || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q   <= cmd_e'(cmd_i);
      pid_q   <= process_id_i;
      page_q  <= page_i;
      frame_q <= frame_in_i;
      npc_q   <= new_page_count_i;
    end
    if (finish) begin
      hit_q       <= hit_d;
      frame_out_q <= frame_out_d;
      act_q       <= act_d;
      rm_out_q    <= rm_out_d;
    end
    scan_q    <= scan_d;
    removed_q <= removed_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      eiu_q       <= CFG_W'(CAPACITY);
      policy_q    <= POLICY_FIFO;
      count_q     <= '0;
      fifo_q      <= '0;
      stamp_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      fifo_q      <= fifo_d;
      stamp_q     <= stamp_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_ENTRIES_IN_USE: eiu_q    <= cfg_data_i;
          REG_REPLACE_POLICY: policy_q <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign hit_o           = hit_q;
  assign frame_out_o     = frame_out_q;
  assign fill_action_o   = act_q;
  assign removed_count_o = rm_out_q;

endmodule
